// ===== src/lct_pkg.sv =====
package lct_pkg;

	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// register file: byte address 4*i, word index in paddr above bit 1
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_LEVEL = '0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ILOAD,
		ST_IDIV,
		ST_IWR,
		ST_END,
		ST_SDIV,
		ST_EMIT
	} lct_state_t;

	typedef struct packed {
		logic load_sample;
		logic mul;
		logic div_load;
		logic div_sel_speed;
		logic div_step;
		logic write_found;
		logic emit;
		logic end_clear;
	} lct_cmd_t;

	typedef struct packed {
		logic hit;
		logic last_in;
		logic last;
		logic div_done;
		logic found_zero;
		logic time_equal;
		logic out_free;
	} lct_stat_t;

endpackage

// ===== src/level_crossing_tracker_unit.sv =====
// channel  | handshake           | carries
// ---------+---------------------+----------------------------------------------
// in       | in_valid / in_stall | sample_position, sample_value, snapshot_time,
//          |                     | last_sample
// out      | out_valid/out_stall | crossing_time, crossing_position, front_speed,
//          |                     | speed_invalid
// cfg      | apb psel / penable  | level_value at byte address 0
//
// an item with no crossing against its neighbour is taken without stalling the input
// an item that makes a crossing stalls the input through multiply, divider load,
//   the shared restoring divider at one quotient bit a cycle, and the position write
// the end of a snapshot runs the END state, then speed division and EMIT when a speed is divided
// reset is asynchronous and clears level, reference position and time
// a stalled output holds its item; the next snapshot runs on until it has to emit
module level_crossing_tracker_unit #(
	parameter int WORD_WIDTH = lct_pkg::WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = lct_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [lct_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [((WORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((WORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic                                  pready,
	// samples
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [WORD_WIDTH-1:0]          sample_position,
	input  logic signed [WORD_WIDTH-1:0]          sample_value,
	input  logic [WORD_WIDTH-1:0]                 snapshot_time,
	input  logic                                  last_sample,
	// crossings
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [WORD_WIDTH-1:0]                 crossing_time,
	output logic signed [WORD_WIDTH-1:0]          crossing_position,
	output logic signed [WORD_WIDTH-1:0]          front_speed,
	output logic                                  speed_invalid
);
	import lct_pkg::*;

	localparam int APB_W = (WORD_WIDTH > 32) ? 64 : 32;

	logic [WORD_WIDTH-1:0] level_q;
	logic [CFG_IDX_W-1:0]  reg_idx;
	logic                  cfg_wr;
	lct_cmd_t              cmd;
	lct_stat_t             stat;

	// register index sits above the byte offset
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cfg_wr && reg_idx == CFG_REG_LEVEL) begin
			level_q <= pwdata[WORD_WIDTH-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			CFG_REG_LEVEL: prdata = APB_W'(level_q);
			default:       prdata = '0;
		endcase
	end

	// sequencer: one state per phase of the crossing and speed work
	lct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// sample registers, interpolation, speed and the output register
	lct_datapath #(
		.W (WORD_WIDTH),
		.F (FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.level             (level_q),
		.sample_position   (sample_position),
		.sample_value      (sample_value),
		.snapshot_time     (snapshot_time),
		.last_sample       (last_sample),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.crossing_time     (crossing_time),
		.crossing_position (crossing_position),
		.front_speed       (front_speed),
		.speed_invalid     (speed_invalid)
	);

endmodule

// ===== src/lct_divider.sv =====
module lct_divider #(
	parameter int DIVW = 66,
	parameter int QW   = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            step,
	input  logic [DIVW-1:0] dividend,
	input  logic [QW-1:0]   divisor,
	output logic [QW-1:0]   quotient,
	output logic            ovf,
	output logic            done
);
	localparam int HIW = DIVW - QW;
	localparam int CW  = $clog2(QW + 1);

	logic [QW-1:0] rem_q;
	logic [QW-1:0] lo_q;
	logic [QW-1:0] quo_q;
	logic [QW-1:0] dsr_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_q;

	logic [HIW-1:0] hi;
	logic [HIW-1:0] dsr_ext;
	logic [QW:0]    shifted;
	logic           ge;

	always_comb begin
		hi      = dividend[DIVW-1:QW];
		dsr_ext = HIW'(divisor);
		shifted = {rem_q, lo_q[QW-1]};
		ge      = shifted >= {1'b0, dsr_q};
	end

	// restoring division, one quotient bit per cycle while step is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= QW'(hi);
			lo_q  <= dividend[QW-1:0];
			quo_q <= '0;
			dsr_q <= divisor;
			ovf_q <= hi >= dsr_ext;
		end else if (step) begin
			rem_q <= ge ? QW'(shifted - {1'b0, dsr_q}) : QW'(shifted);
			lo_q  <= {lo_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign ovf      = ovf_q;
	assign done     = cnt_q == CW'(QW);

endmodule

// ===== src/lct_datapath.sv =====
module lct_datapath #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lct_pkg::lct_cmd_t   cmd,
	output lct_pkg::lct_stat_t  stat,
	input  logic signed [W-1:0] level,
	input  logic signed [W-1:0] sample_position,
	input  logic signed [W-1:0] sample_value,
	input  logic [W-1:0]        snapshot_time,
	input  logic                last_sample,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [W-1:0]        crossing_time,
	output logic signed [W-1:0] crossing_position,
	output logic signed [W-1:0] front_speed,
	output logic                speed_invalid
);
	import lct_pkg::*;

	localparam int QW   = W + 1;
	localparam int PW   = 2 * QW;
	localparam int SW   = QW + F;
	localparam int DIVW = (PW > SW) ? PW : SW;

	// sign and magnitude of a - b
	function automatic logic [W+1:0] mag_diff(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] d;
		d = {a[W-1], a} - {b[W-1], b};
		return {d[W], (d[W] ? (~d + 1'b1) : d)};
	endfunction

	logic signed [W-1:0] prev_pos_q, prev_val_q;
	logic                have_prev_q;
	logic                last_q;
	logic [W-1:0]        time_q;
	logic [W-1:0]        x0_q;
	logic                sign_q;
	logic [QW-1:0]       m1_q, m2_q, m3_q;
	logic [PW-1:0]       prod_q;
	logic [W-1:0]        found_q;
	logic [W-1:0]        last_pos_q, last_time_q;
	logic                spd_neg_q, spd_nd_q;
	logic                out_valid_q;
	logic [W-1:0]        out_time_q, out_pos_q, out_speed_q;
	logic                out_inv_q;

	logic [W+1:0]    d1, d2, d3, dn;
	logic            hit;
	logic            nd;
	logic [W-1:0]    md;
	logic [DIVW-1:0] div_dividend;
	logic [QW-1:0]   div_divisor;
	logic [QW-1:0]   quo;
	logic            div_ovf, div_done;
	logic [W-1:0]    qi;
	logic            teq, sat;
	logic [W-1:0]    speed;
	logic            invalid;

	always_comb begin
		d1  = mag_diff(level, prev_val_q);
		d2  = mag_diff(sample_position, prev_pos_q);
		d3  = mag_diff(sample_value, prev_val_q);
		hit = have_prev_q &&
			((prev_val_q < level && level < sample_value) ||
			 (level < prev_val_q && sample_value < level));

		dn = mag_diff(found_q, last_pos_q);
		nd = time_q < last_time_q;
		md = nd ? (last_time_q - time_q) : (time_q - last_time_q);

		div_dividend = cmd.div_sel_speed ? (DIVW'(dn[W:0]) << F) : DIVW'(prod_q);
		div_divisor  = cmd.div_sel_speed ? QW'(md) : m3_q;

		qi  = div_ovf ? '0 : quo[W-1:0];
		teq = time_q == last_time_q;

		// clamp to the signed range
		sat = div_ovf ||
			(!spd_neg_q && quo > {2'b00, {(W-1){1'b1}}}) ||
			(spd_neg_q && quo > {2'b01, {(W-1){1'b0}}});
		if (teq) begin
			speed   = '0;
			invalid = 1'b1;
		end else begin
			if (sat) begin
				speed = spd_neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				speed = spd_neg_q ? (W'(0) - quo[W-1:0]) : quo[W-1:0];
			end
			invalid = spd_nd_q || sat;
		end
	end

	lct_divider #(
		.DIVW (DIVW),
		.QW   (QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quo),
		.ovf      (div_ovf),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			found_q     <= '0;
			last_pos_q  <= '0;
			last_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_sample) begin
				have_prev_q <= 1'b1;
			end
			if (cmd.write_found) begin
				found_q <= sign_q ? (x0_q - qi) : (x0_q + qi);
			end
			if (cmd.emit) begin
				last_pos_q  <= found_q;
				last_time_q <= time_q;
			end
			if (cmd.end_clear) begin
				have_prev_q <= 1'b0;
				found_q     <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			prev_pos_q <= sample_position;
			prev_val_q <= sample_value;
			last_q     <= last_sample;
			time_q     <= snapshot_time;
			x0_q       <= prev_pos_q;
			m1_q       <= d1[W:0];
			m2_q       <= d2[W:0];
			m3_q       <= d3[W:0];
			sign_q     <= d1[W+1] ^ d2[W+1] ^ d3[W+1];
		end
		if (cmd.mul) begin
			prod_q <= PW'(m1_q) * PW'(m2_q);
		end
		if (cmd.div_load && cmd.div_sel_speed) begin
			spd_neg_q <= dn[W+1] ^ nd;
			spd_nd_q  <= nd;
		end
		if (cmd.emit) begin
			out_time_q  <= time_q;
			out_pos_q   <= found_q;
			out_speed_q <= speed;
			out_inv_q   <= invalid;
		end
	end

	always_comb begin
		stat.hit        = hit;
		stat.last_in    = last_sample;
		stat.last       = last_q;
		stat.div_done   = div_done;
		stat.found_zero = found_q == '0;
		stat.time_equal = teq;
		stat.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid         = out_valid_q;
	assign crossing_time     = out_time_q;
	assign crossing_position = out_pos_q;
	assign front_speed       = out_speed_q;
	assign speed_invalid     = out_inv_q;

endmodule

// ===== src/lct_ctrl.sv =====
module lct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lct_pkg::lct_stat_t stat,
	output lct_pkg::lct_cmd_t  cmd
);
	import lct_pkg::*;

	lct_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (stat.hit) begin
						state_d = ST_MUL;
					end else if (stat.last_in) begin
						state_d = ST_END;
					end
				end
			end
			ST_MUL:   state_d = ST_ILOAD;
			ST_ILOAD: state_d = ST_IDIV;
			ST_IDIV: begin
				if (stat.div_done) begin
					state_d = ST_IWR;
				end
			end
			ST_IWR: state_d = stat.last ? ST_END : ST_IDLE;
			ST_END: begin
				if (stat.found_zero) begin
					state_d = ST_IDLE;
				end else if (stat.time_equal) begin
					if (stat.out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_SDIV;
				end
			end
			ST_SDIV: begin
				if (stat.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				cmd.load_sample = in_valid;
			end
			ST_MUL:   cmd.mul = 1'b1;
			ST_ILOAD: cmd.div_load = 1'b1;
			ST_IDIV:  cmd.div_step = !stat.div_done;
			ST_IWR:   cmd.write_found = 1'b1;
			ST_END: begin
				cmd.div_sel_speed = 1'b1;
				cmd.div_load      = !stat.found_zero && !stat.time_equal;
				cmd.emit          = !stat.found_zero && stat.time_equal && stat.out_free;
				cmd.end_clear     = stat.found_zero || (stat.time_equal && stat.out_free);
			end
			ST_SDIV: cmd.div_step = !stat.div_done;
			ST_EMIT: begin
				cmd.emit      = stat.out_free;
				cmd.end_clear = stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== src/lct_checker.sv =====
module lct_checker #(
	parameter int WORD_WIDTH = lct_pkg::WORD_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  last_sample,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [WORD_WIDTH-1:0] crossing_time,
	input logic [WORD_WIDTH-1:0] crossing_position,
	input logic [WORD_WIDTH-1:0] front_speed,
	input logic                  speed_invalid
);

	// a reported crossing is never at position zero
	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> crossing_position != '0)
		else $error("crossing reported at position zero");

	// the end of a snapshot always holds off the next item
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_sample |=> in_stall)
		else $error("item taken straight after the last sample");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(crossing_time) && $stable(crossing_position)
			&& $stable(front_speed) && $stable(speed_invalid))
		else $error("output item changed while stalled");

endmodule

bind level_crossing_tracker_unit lct_checker #(.WORD_WIDTH(WORD_WIDTH)) u_lct_checker (.*);
